@@ hdl/kwm_pkg.sv @@
// Package for the k-way merge heap: field widths, action codes, the heap entry type,
// the command and status types and the entry ordering function.
// Used by every module of the block but kwm_ram. It depends on nothing else.
package kwm_pkg;

    localparam int WAYS_DEF = 16;
    localparam int EPOCH_W  = 40;
    localparam int MS_W     = 10;
    localparam int SYM_W    = 64;
    localparam int SRC_W    = 4;
    localparam int TKEY_W   = EPOCH_W + MS_W;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_BUILD   = 2'd1;
    localparam logic [1:0] ACT_REPLACE = 2'd2;

    // One heap entry. An exhausted entry holds a zero key.
    typedef struct packed {
        logic              done;
        logic [TKEY_W-1:0] tkey;
        logic [SYM_W-1:0]  sym;
        logic [SRC_W-1:0]  src;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start_build;
        logic start_replace;
        logic bld_capture;
        logic rep_capture;
        logic bld_read;
        logic sift_read;
        logic cmp_step;
        logic bld_dec;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic leaf;
        logic sift_done;
        logic bld_zero;
        logic out_busy;
    } status_t;

    // True when entry a orders strictly before entry b; exhausted entries sort last.
    function automatic logic orders_before(entry_t a, entry_t b);
        logic res;
        if (a.done != b.done)
        begin
            res = !a.done;
        end
        else if (a.done)
        begin
            res = 1'b0;
        end
        else if (a.tkey != b.tkey)
        begin
            res = a.tkey < b.tkey;
        end
        else
        begin
            res = a.sym < b.sym;
        end
        return res;
    endfunction

endpackage

@@ hdl/kwm_ram.sv @@
// Generic RAM with one write port and two registered read ports.
// It depends on nothing else.
module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ hdl/kwm_ctrl.sv @@
// Controller state machine of the merge heap: sequences load, build, replace, sift and report.
// Depends on kwm_pkg for the command and status types and the action codes.
module kwm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       action,
    output logic             in_stall,
    input  kwm_pkg::status_t sts,
    output kwm_pkg::cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_REP_RD   = 10'b0000000010,
        S_REP_LD   = 10'b0000000100,
        S_BLD_RD   = 10'b0000001000,
        S_BLD_LD   = 10'b0000010000,
        S_SIFT_RD  = 10'b0000100000,
        S_SIFT_CMP = 10'b0001000000,
        S_NEXT     = 10'b0010000000,
        S_ROOT_RD  = 10'b0100000000,
        S_REPORT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   build_reg, build_next;

    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        build_next = build_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action)
                        kwm_pkg::ACT_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        kwm_pkg::ACT_BUILD:
                        begin
                            cmd.start_build = 1'b1;
                            build_next      = 1'b1;
                            state_next      = sts.count_zero ? S_REPORT : S_BLD_RD;
                        end
                        kwm_pkg::ACT_REPLACE:
                        begin
                            cmd.start_replace = 1'b1;
                            build_next        = 1'b0;
                            state_next        = sts.count_zero ? S_REPORT : S_REP_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_REP_RD:
            begin
                state_next = S_REP_LD;
            end
            S_REP_LD:
            begin
                cmd.rep_capture = 1'b1;
                state_next      = S_SIFT_RD;
            end
            S_BLD_RD:
            begin
                cmd.bld_read = 1'b1;
                state_next   = S_BLD_LD;
            end
            S_BLD_LD:
            begin
                cmd.bld_capture = 1'b1;
                state_next      = S_SIFT_RD;
            end
            S_SIFT_RD:
            begin
                cmd.sift_read = 1'b1;
                state_next    = sts.leaf ? S_NEXT : S_SIFT_CMP;
            end
            S_SIFT_CMP:
            begin
                cmd.cmp_step = 1'b1;
                state_next   = sts.sift_done ? S_NEXT : S_SIFT_RD;
            end
            S_NEXT:
            begin
                if (build_reg && !sts.bld_zero)
                begin
                    cmd.bld_dec = 1'b1;
                    state_next  = S_BLD_RD;
                end
                else
                begin
                    state_next = S_ROOT_RD;
                end
            end
            S_ROOT_RD:
            begin
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            build_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            build_reg <= build_next;
        end
    end

endmodule

@@ hdl/kwm_datapath.sv @@
// Datapath of the merge heap: entry RAM, sinking entry, indexes, count and output word.
// Depends on kwm_pkg and kwm_ram.
module kwm_datapath #(
    parameter int WAYS = kwm_pkg::WAYS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kwm_pkg::cmd_t                cmd,
    output kwm_pkg::status_t             sts,
    input  logic [kwm_pkg::EPOCH_W-1:0]  epoch_seconds,
    input  logic [kwm_pkg::MS_W-1:0]     millis,
    input  logic [kwm_pkg::SYM_W-1:0]    symbol,
    input  logic                         exhausted,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [kwm_pkg::SRC_W-1:0]    min_source,
    output logic [kwm_pkg::EPOCH_W-1:0]  min_epoch,
    output logic [kwm_pkg::MS_W-1:0]     min_millis,
    output logic [kwm_pkg::SYM_W-1:0]    min_symbol,
    output logic                         all_done
);

    localparam int AW    = $clog2(WAYS);
    localparam int CNT_W = $clog2(WAYS + 1);
    localparam int CW    = AW + 2;
    localparam int EW    = $bits(kwm_pkg::entry_t);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    bld_reg, bld_next;
    kwm_pkg::entry_t  cur_reg, cur_next;
    kwm_pkg::entry_t  newkey_reg, newkey_next;
    logic             out_valid_reg, out_valid_next;

    logic [kwm_pkg::SRC_W-1:0]   src_reg;
    logic [kwm_pkg::EPOCH_W-1:0] epoch_reg;
    logic [kwm_pkg::MS_W-1:0]    ms_reg;
    logic [kwm_pkg::SYM_W-1:0]   sym_reg;
    logic                        done_reg;

    logic            we;
    logic [AW-1:0]   waddr, raddr_a, raddr_b;
    kwm_pkg::entry_t wdata, rdata_a, rdata_b, in_entry, best;
    logic [EW-1:0]   rd_a_bits, rd_b_bits;
    logic [CW-1:0]   lc, rc, n_ext;
    logic            r_ok, sel_l, sel_r;

    kwm_ram #(.WIDTH(EW), .DEPTH(WAYS)) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a_bits),
        .rdata_b (rd_b_bits)
    );

    assign rdata_a = kwm_pkg::entry_t'(rd_a_bits);
    assign rdata_b = kwm_pkg::entry_t'(rd_b_bits);

    // Child indexes of the current node and their range checks.
    assign lc    = {1'b0, idx_reg, 1'b1};
    assign rc    = lc + CW'(1);
    assign n_ext = CW'(count_reg);
    assign r_ok  = rc < n_ext;

    // Input word as an entry; an exhausted record keeps a zero key.
    always_comb
    begin
        in_entry.done = exhausted;
        in_entry.tkey = exhausted ? '0 : {epoch_seconds, millis};
        in_entry.sym  = exhausted ? '0 : symbol;
        in_entry.src  = kwm_pkg::SRC_W'(count_reg);
    end

    // Pick the smallest of the sinking entry and its two children; ties keep the parent.
    always_comb
    begin
        best  = cur_reg;
        sel_l = 1'b0;
        sel_r = 1'b0;
        if (kwm_pkg::orders_before(rdata_a, cur_reg))
        begin
            best  = rdata_a;
            sel_l = 1'b1;
        end
        if (r_ok && kwm_pkg::orders_before(rdata_b, best))
        begin
            best  = rdata_b;
            sel_l = 1'b0;
            sel_r = 1'b1;
        end
    end

    assign sts.count_zero = (count_reg == '0);
    assign sts.leaf       = (lc >= n_ext);
    assign sts.sift_done  = !(sel_l || sel_r);
    assign sts.bld_zero   = (bld_reg == '0);
    assign sts.out_busy   = out_valid_reg && out_stall;

    // RAM port selection.
    always_comb
    begin
        we      = 1'b0;
        waddr   = idx_reg;
        wdata   = cur_reg;
        raddr_a = '0;
        raddr_b = AW'(rc);
        if (cmd.load && (count_reg < CNT_W'(WAYS)))
        begin
            we    = 1'b1;
            waddr = AW'(count_reg);
            wdata = in_entry;
        end
        else if (cmd.sift_read && sts.leaf)
        begin
            we = 1'b1;
        end
        else if (cmd.cmp_step)
        begin
            we    = 1'b1;
            wdata = best;
        end
        if (cmd.bld_read)
        begin
            raddr_a = bld_reg;
        end
        else if (cmd.sift_read)
        begin
            raddr_a = AW'(lc);
        end
    end

    // Next values of the working registers.
    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        bld_next       = bld_reg;
        cur_next       = cur_reg;
        newkey_next    = newkey_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.load && (count_reg < CNT_W'(WAYS)))
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.start_build)
        begin
            bld_next = AW'((count_reg - CNT_W'(1)) >> 1);
        end
        if (cmd.start_replace)
        begin
            newkey_next = in_entry;
        end
        if (cmd.rep_capture)
        begin
            cur_next     = newkey_reg;
            cur_next.src = rdata_a.src;
            idx_next     = '0;
        end
        if (cmd.bld_capture)
        begin
            cur_next = rdata_a;
            idx_next = bld_reg;
        end
        if (cmd.cmp_step && sel_l)
        begin
            idx_next = AW'(lc);
        end
        else if (cmd.cmp_step && sel_r)
        begin
            idx_next = AW'(rc);
        end
        if (cmd.bld_dec)
        begin
            bld_next = bld_reg - AW'(1);
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers; the output word loads from the root read.
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        bld_reg    <= bld_next;
        cur_reg    <= cur_next;
        newkey_reg <= newkey_next;
        if (cmd.out_load)
        begin
            if (sts.count_zero)
            begin
                src_reg   <= '0;
                epoch_reg <= '0;
                ms_reg    <= '0;
                sym_reg   <= '0;
                done_reg  <= 1'b1;
            end
            else
            begin
                src_reg   <= rdata_a.src;
                epoch_reg <= rdata_a.tkey[kwm_pkg::TKEY_W-1:kwm_pkg::MS_W];
                ms_reg    <= rdata_a.tkey[kwm_pkg::MS_W-1:0];
                sym_reg   <= rdata_a.sym;
                done_reg  <= rdata_a.done;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign min_source = src_reg;
    assign min_epoch  = epoch_reg;
    assign min_millis = ms_reg;
    assign min_symbol = sym_reg;
    assign all_done   = done_reg;

endmodule

@@ hdl/k_way_merge_min_heap.sv @@
// K-way merge engine on a binary min-heap held in a two-read-port RAM; one item at a time.
// Load takes its word without stalling. Replace reads the root, then sifts the new key down
// one level per read and compare step until it settles or reaches a leaf; build does the
// same sift for each parent node from the last one down to the root. Both then read the root.
// On an empty heap the result word is loaded without a sift; input stalls until the word is loaded.
// Reset clears the entry count and output valid; RAM contents are not cleared.
module k_way_merge_min_heap #(
    parameter int WAYS = kwm_pkg::WAYS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [kwm_pkg::EPOCH_W-1:0]  epoch_seconds,
    input  logic [kwm_pkg::MS_W-1:0]     millis,
    input  logic [kwm_pkg::SYM_W-1:0]    symbol,
    input  logic                         exhausted,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [kwm_pkg::SRC_W-1:0]    min_source,
    output logic [kwm_pkg::EPOCH_W-1:0]  min_epoch,
    output logic [kwm_pkg::MS_W-1:0]     min_millis,
    output logic [kwm_pkg::SYM_W-1:0]    min_symbol,
    output logic                         all_done
);

    kwm_pkg::cmd_t    cmd;
    kwm_pkg::status_t sts;

    kwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    kwm_datapath #(.WAYS(WAYS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .epoch_seconds (epoch_seconds),
        .millis        (millis),
        .symbol        (symbol),
        .exhausted     (exhausted),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .min_source    (min_source),
        .min_epoch     (min_epoch),
        .min_millis    (min_millis),
        .min_symbol    (min_symbol),
        .all_done      (all_done)
    );

endmodule

@@ hdl/kwm_checker.sv @@
// Port-level checker for the merge heap, bound to the top level.
// Depends on kwm_pkg for the action codes and field widths.
module kwm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [1:0]                   action,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [kwm_pkg::EPOCH_W-1:0]  min_epoch,
    input logic [kwm_pkg::MS_W-1:0]     min_millis,
    input logic [kwm_pkg::SYM_W-1:0]    min_symbol,
    input logic                         all_done
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(min_epoch) && $stable(min_symbol))
        else $error("stalled result word changed");

    // An exhausted result carries a zero key.
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && all_done |-> min_epoch == '0 && min_millis == '0 && min_symbol == '0)
        else $error("exhausted result with nonzero key");

    // A load word produces no result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == kwm_pkg::ACT_LOAD && !out_valid |=> !out_valid)
        else $error("load produced a result");

    // Build and replace keep the input side busy until their result is formed.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall
        && (action == kwm_pkg::ACT_BUILD || action == kwm_pkg::ACT_REPLACE) |=> in_stall)
        else $error("input accepted during heap operation");

endmodule

bind k_way_merge_min_heap kwm_checker u_kwm_checker (.*);

@@ tb/sv/tb_k_way_merge_min_heap.sv @@
// Self-checking testbench for the k-way merge min-heap engine.
// Depends on kwm_pkg and k_way_merge_min_heap; a built-in heap predictor computes
// every expected minimum word.
module tb_k_way_merge_min_heap;

    localparam int NWAYS = kwm_pkg::WAYS_DEF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [kwm_pkg::SRC_W-1:0]   src;
        logic [kwm_pkg::EPOCH_W-1:0] epoch;
        logic [kwm_pkg::MS_W-1:0]    ms;
        logic [kwm_pkg::SYM_W-1:0]   sym;
        logic                        done;
    } min_word_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] action;
    logic [kwm_pkg::EPOCH_W-1:0] epoch_seconds;
    logic [kwm_pkg::MS_W-1:0] millis;
    logic [kwm_pkg::SYM_W-1:0] symbol;
    logic exhausted;
    logic out_valid;
    logic out_stall;
    logic [kwm_pkg::SRC_W-1:0] min_source;
    logic [kwm_pkg::EPOCH_W-1:0] min_epoch;
    logic [kwm_pkg::MS_W-1:0] min_millis;
    logic [kwm_pkg::SYM_W-1:0] min_symbol;
    logic all_done;

    // Predictor state: a mirror of the heap array.
    kwm_pkg::entry_t heap_mirror[NWAYS];
    int              mirror_count;
    min_word_t       min_queue[$];
    int              fail_count;
    int              result_count;
    int              cycle_count;
    bit              hold_off;

    k_way_merge_min_heap dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .epoch_seconds(epoch_seconds), .millis(millis),
        .symbol(symbol), .exhausted(exhausted), .out_valid(out_valid),
        .out_stall(out_stall), .min_source(min_source), .min_epoch(min_epoch),
        .min_millis(min_millis), .min_symbol(min_symbol), .all_done(all_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle counter with a hard limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_k_way_merge_min_heap: FAIL");
            $finish;
        end
    end

    // Strict ordering of two mirrored entries; exhausted ones go last.
    function automatic bit orders_first(kwm_pkg::entry_t a, kwm_pkg::entry_t b);
        if (a.done != b.done)
            return !a.done;
        if (a.done)
            return 1'b0;
        if (a.tkey != b.tkey)
            return a.tkey < b.tkey;
        return a.sym < b.sym;
    endfunction

    task automatic sift_mirror(input int start);
        int i;
        int l;
        int r;
        int best;
        kwm_pkg::entry_t t;
        i = start;
        forever
        begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            best = i;
            if (l < mirror_count && orders_first(heap_mirror[l], heap_mirror[best]))
                best = l;
            if (r < mirror_count && orders_first(heap_mirror[r], heap_mirror[best]))
                best = r;
            if (best == i)
                return;
            t = heap_mirror[i];
            heap_mirror[i] = heap_mirror[best];
            heap_mirror[best] = t;
            i = best;
        end
    endtask

    function automatic kwm_pkg::entry_t make_entry(logic [kwm_pkg::EPOCH_W-1:0] ep,
                                                   logic [kwm_pkg::MS_W-1:0] ms,
                                                   logic [kwm_pkg::SYM_W-1:0] sy, logic ex);
        kwm_pkg::entry_t e;
        e.done = ex;
        e.tkey = ex ? '0 : {ep, ms};
        e.sym  = ex ? '0 : sy;
        e.src  = '0;
        return e;
    endfunction

    function automatic min_word_t root_word();
        min_word_t w;
        w = '0;
        if (mirror_count == 0 || heap_mirror[0].done)
        begin
            w.done = 1'b1;
            if (mirror_count != 0)
                w.src = heap_mirror[0].src;
        end
        else
        begin
            w.src   = heap_mirror[0].src;
            w.epoch = heap_mirror[0].tkey[kwm_pkg::TKEY_W-1:kwm_pkg::MS_W];
            w.ms    = heap_mirror[0].tkey[kwm_pkg::MS_W-1:0];
            w.sym   = heap_mirror[0].sym;
        end
        return w;
    endfunction

    // Apply one accepted word to the mirror and queue the expected minimum.
    task automatic predict_min(input logic [1:0] act, input logic [kwm_pkg::EPOCH_W-1:0] ep,
                               input logic [kwm_pkg::MS_W-1:0] ms,
                               input logic [kwm_pkg::SYM_W-1:0] sy, input logic ex);
        kwm_pkg::entry_t e;
        int i;
        e = make_entry(ep, ms, sy, ex);
        case (act)
            kwm_pkg::ACT_LOAD:
            begin
                if (mirror_count < NWAYS)
                begin
                    e.src = mirror_count[kwm_pkg::SRC_W-1:0];
                    heap_mirror[mirror_count] = e;
                    mirror_count++;
                end
            end
            kwm_pkg::ACT_BUILD:
            begin
                for (i = mirror_count / 2; i >= 0; i--)
                    sift_mirror(i);
                min_queue.insert(min_queue.size(), root_word());
            end
            kwm_pkg::ACT_REPLACE:
            begin
                if (mirror_count > 0)
                begin
                    e.src = heap_mirror[0].src;
                    heap_mirror[0] = e;
                    sift_mirror(0);
                end
                min_queue.insert(min_queue.size(), root_word());
            end
            default:
            begin
            end
        endcase
    endtask

    // Random gap: mostly short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one word and wait until the block takes it; valid drops only for a gap.
    task automatic send_word(input logic [1:0] act, input logic [kwm_pkg::EPOCH_W-1:0] ep,
                             input logic [kwm_pkg::MS_W-1:0] ms,
                             input logic [kwm_pkg::SYM_W-1:0] sy,
                             input logic ex, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        epoch_seconds <= ep;
        millis        <= ms;
        symbol        <= sy;
        exhausted     <= ex;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_min(act, ep, ms, sy, ex);
    endtask

    // Drop valid once no further word follows right away.
    task automatic release_input();
        in_valid <= 1'b0;
    endtask

    function automatic logic [kwm_pkg::SYM_W-1:0] rand_sym();
        return {$urandom(), $urandom()};
    endfunction

    // Random record; half the time with narrow keys so that ties happen often.
    task automatic send_record(input logic [1:0] act, input bit gaps);
        logic [kwm_pkg::EPOCH_W-1:0] ep;
        logic [kwm_pkg::MS_W-1:0] ms;
        logic [kwm_pkg::SYM_W-1:0] sy;
        int m;
        m = $urandom_range(0, 9);
        if (m < 5)
        begin
            ep = kwm_pkg::EPOCH_W'($urandom_range(0, 3));
            ms = kwm_pkg::MS_W'($urandom_range(0, 2));
            sy = kwm_pkg::SYM_W'($urandom_range(0, 3));
        end
        else
        begin
            ep = kwm_pkg::EPOCH_W'({$urandom(), $urandom()});
            ms = kwm_pkg::MS_W'($urandom_range(0, 999));
            sy = rand_sym();
        end
        send_word(act, ep, ms, sy, $urandom_range(0, 5) == 0, gaps);
    endtask

    task automatic test_empty_and_unused();
        send_word(kwm_pkg::ACT_BUILD, '0, '0, '0, 1'b0, 1'b0);
        send_word(kwm_pkg::ACT_REPLACE, '1, 10'd999, '1, 1'b0, 1'b0);
        send_word(ACT_UNUSED, '1, 10'd999, '1, 1'b1, 1'b0);
    endtask

    task automatic test_field_extremes();
        send_word(kwm_pkg::ACT_LOAD, '1, 10'd999, '1, 1'b0, 1'b0);
        send_word(kwm_pkg::ACT_LOAD, '0, '0, '0, 1'b0, 1'b0);
        send_word(kwm_pkg::ACT_LOAD, '0, '0, 64'h4142_0000_0000_0000, 1'b0, 1'b0);
        send_word(kwm_pkg::ACT_LOAD, 40'h55_5555_5555, 10'h2AA, 64'hAAAA_AAAA_5555_5555,
                  1'b0, 1'b0);
        send_word(kwm_pkg::ACT_LOAD, '1, 10'd999, '1, 1'b1, 1'b0);
        send_word(kwm_pkg::ACT_REPLACE, 40'd7, 10'd1, 64'd3, 1'b0, 1'b0);
        send_word(kwm_pkg::ACT_BUILD, '0, '0, '0, 1'b0, 1'b0);
        send_word(kwm_pkg::ACT_LOAD, '0, '0, '0, 1'b0, 1'b0);
        repeat (6) send_word(kwm_pkg::ACT_REPLACE, '1, '1, '1, 1'b1, 1'b0);
        send_word(kwm_pkg::ACT_REPLACE, '0, '0, '1, 1'b0, 1'b0);
    endtask

    // Fill past capacity so the extra loads are dropped, then build and replace.
    task automatic test_full_heap();
        repeat (NWAYS + 3) send_record(kwm_pkg::ACT_LOAD, 1'b1);
        send_word(kwm_pkg::ACT_BUILD, '0, '0, '0, 1'b0, 1'b1);
        repeat (NWAYS + 8) send_record(kwm_pkg::ACT_REPLACE, 1'b1);
    endtask

    // Receiver holds off a long stretch while merge words keep coming.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (30) send_record(kwm_pkg::ACT_REPLACE, 1'b0);
                release_input();
            end
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
        join
    endtask

    // Merge rounds with random sizes; the heap is not reset between rounds, so rounds
    // refill only as far as capacity allows and then keep replacing.
    task automatic test_random_merge(input int budget);
        int sent;
        int n;
        int k;
        sent = 0;
        while (sent < budget)
        begin
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++)
                send_record(kwm_pkg::ACT_LOAD, 1'b1);
            sent += n;
            if ($urandom_range(0, 9) != 0)
            begin
                send_record(kwm_pkg::ACT_BUILD, 1'b1);
                sent++;
            end
            n = $urandom_range(1, 20);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_word(ACT_UNUSED, '0, '0, '0, 1'b0, 1'b1);
                else
                    send_record(kwm_pkg::ACT_REPLACE, 1'b1);
            end
            sent += n;
        end
        release_input();
    endtask

    // Output stall: random gaps, or solid during a hold-off.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 99) < 20)
            begin
                out_stall <= 1'b1;
                repeat (gap_len()) @(posedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        min_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (min_queue.size() == 0)
            begin
                $error("unexpected result word, source %0d", min_source);
                fail_count++;
            end
            else
            begin
                w = min_queue.pop_front();
                if (min_source !== w.src)
                begin
                    $error("min_source expected %0d actual %0d", w.src, min_source);
                    fail_count++;
                end
                if (min_epoch !== w.epoch)
                begin
                    $error("min_epoch expected %0h actual %0h", w.epoch, min_epoch);
                    fail_count++;
                end
                if (min_millis !== w.ms)
                begin
                    $error("min_millis expected %0d actual %0d", w.ms, min_millis);
                    fail_count++;
                end
                if (min_symbol !== w.sym)
                begin
                    $error("min_symbol expected %0h actual %0h", w.sym, min_symbol);
                    fail_count++;
                end
                if (all_done !== w.done)
                begin
                    $error("all_done expected %0b actual %0b", w.done, all_done);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = kwm_pkg::ACT_LOAD;
        epoch_seconds = '0;
        millis        = '0;
        symbol        = '0;
        exhausted     = 1'b0;
        mirror_count  = 0;
        fail_count    = 0;
        result_count  = 0;
        cycle_count   = 0;
        hold_off      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_unused();
        test_field_extremes();
        test_full_heap();
        test_backpressure();
        test_random_merge(1150);

        // Drain, then allow for any trailing activity.
        while (min_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered empty, full, exhausted and tied heaps; %0d result words checked.",
                 result_count);
        if (fail_count == 0 && min_queue.size() == 0)
            $display("tb_k_way_merge_min_heap: PASS");
        else
            $display("tb_k_way_merge_min_heap: FAIL");
        $finish;
    end

endmodule
